// ----- rtl/aofq_pkg.sv -----
// Shared types and constants for the box overlap query block.
package aofq_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int FLAG_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // command codes carried in the input tuser
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // one stored table entry
  typedef struct packed {
    logic [FLAG_BITS-1:0] flags;
    logic [15:0]          h;
    logic [15:0]          w;
    logic [31:0]          y;
    logic [31:0]          x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/aofq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module aofq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/aabb_overlap_flag_query.sv -----
// Top level: box table with first-match overlap and flag query.
//
//  channel  dir  payload                                         handshake
//  s_*      in   tuser: cmd; tdata: box and mask fields          tvalid/tready
//  m_*      out  tuser: status, hit; tdata: hit_flags            tvalid/tready
//
// Clear and append update the table as they are taken, then pass to the answer state.
// A query reads one entry per cycle from the entry RAM in table order and
// stops at the first match or at the fill point, then loads the answer.
// The single RAM read port sets that rate.
// Reset empties the table (entry_count only) and drops any pending answer.
// A stalled output holds its beat; the next item is taken as soon as the
// answer sits in the output register, and its own answer waits for the slot.
module aabb_overlap_flag_query
  import aofq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // s_tdata: box_x[31:0], box_y[63:32], box_w[79:64], box_h[95:80],
  //          entry_flags[111:96], require_mask[127:112], any_mask[143:128],
  //          forbid_mask[159:144]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic [1:0]   s_tuser,     // cmd[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,     // hit_flags[15:0]
  output logic [1:0]   m_tuser      // status[0], hit[1]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pend;

  // query held for the whole scan; edges widened so sums never wrap
  logic signed [32:0]   q_x, q_y, q_r, q_t;
  logic [FLAG_BITS-1:0] q_req, q_any, q_forbid;

  logic                 res_status;
  logic                 res_hit;
  logic [FLAG_BITS-1:0] res_flags;

  // input field unpacking
  logic [1:0]  in_cmd;
  logic [31:0] in_x, in_y;
  logic [15:0] in_w, in_h, in_flags, in_req, in_any, in_forbid;

  assign in_cmd    = s_tuser;
  assign in_x      = s_tdata[31:0];
  assign in_y      = s_tdata[63:32];
  assign in_w      = s_tdata[79:64];
  assign in_h      = s_tdata[95:80];
  assign in_flags  = s_tdata[111:96];
  assign in_req    = s_tdata[127:112];
  assign in_any    = s_tdata[143:128];
  assign in_forbid = s_tdata[159:144];

  logic in_fire;
  logic out_free;
  logic table_full;

  assign s_tready   = (state == ST_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (entry_count >= CNT_W'(MAX_ENTRIES));

  // entry RAM: append writes at the fill point, the scan reads in order.
  // Appends happen only in IDLE, so a write never overlaps a scan read.
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;

  assign wr_entry.x     = in_x;
  assign wr_entry.y     = in_y;
  assign wr_entry.w     = in_w;
  assign wr_entry.h     = in_h;
  assign wr_entry.flags = in_flags[FLAG_BITS-1:0];

  assign ram_we    = in_fire && (in_cmd == CMD_APPEND) && !table_full;
  assign ram_raddr = scan_idx[IDX_W-1:0];

  aofq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // compare the entry that came back from the RAM against the query
  logic signed [32:0] c_x, c_y, c_r, c_t;
  logic               box_hit;
  logic               flag_hit;
  logic               match;
  logic               issue;

  assign c_x = {rd_entry.x[31], rd_entry.x};
  assign c_y = {rd_entry.y[31], rd_entry.y};
  assign c_r = c_x + $signed({17'd0, rd_entry.w});
  assign c_t = c_y + $signed({17'd0, rd_entry.h});

  // touching edges count as overlap
  assign box_hit  = !((q_x > c_r) || (q_r < c_x) || (q_t < c_y) || (q_y > c_t));
  assign flag_hit = ((rd_entry.flags & q_req) == q_req)
                    && (|(rd_entry.flags & q_any))
                    && !(|(rd_entry.flags & q_forbid));
  assign match    = rd_pend && box_hit && flag_hit;

  // launch the next read while entries remain and no match has come back
  assign issue = (state == ST_SCAN) && !match && (scan_idx < entry_count);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (in_cmd == CMD_QUERY) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (match || (!issue && !rd_pend)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rd_pend     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;

      if (in_fire) begin
        // only a refused append reports a nonzero status
        res_status <= (in_cmd == CMD_APPEND) && table_full;
        res_hit    <= 1'b0;
        res_flags  <= '0;
        unique case (in_cmd)
          CMD_CLEAR: begin
            entry_count <= '0;
          end
          CMD_APPEND: begin
            if (!table_full) begin
              entry_count <= entry_count + 1'b1;
            end
          end
          CMD_QUERY: begin
            q_x      <= {in_x[31], in_x};
            q_y      <= {in_y[31], in_y};
            q_r      <= {in_x[31], in_x} + $signed({17'd0, in_w});
            q_t      <= {in_y[31], in_y} + $signed({17'd0, in_h});
            q_req    <= in_req[FLAG_BITS-1:0];
            q_any    <= in_any[FLAG_BITS-1:0];
            q_forbid <= in_forbid[FLAG_BITS-1:0];
            scan_idx <= '0;
          end
          default: begin
            // unused command: answer all zeros, touch nothing
          end
        endcase
      end

      // advance the read pointer; record the first match
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (match) begin
        res_hit   <= 1'b1;
        res_flags <= rd_entry.flags;
      end

      // output register: load the answer when the slot is free
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= 16'(res_flags);
        m_tuser  <= {res_hit, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // scan never reads past the filled part of the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= entry_count))
    else $error("scan pointer past fill point");

  // an accepted append into a table with room grows it by one
  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd == CMD_APPEND && !table_full)
      |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("append did not advance fill point");

  // a new output beat only comes out of the answer state
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESP))
    else $error("output beat without finished item");

endmodule

// ----- bench/aabb_overlap_flag_query_test.sv -----
// Self-checking bench for the box table with first-match overlap and flag query.
`timescale 1ns / 100ps

module aabb_overlap_flag_query_test;
  import aofq_pkg::*;

  // cmd value with no meaning: the block must answer all zeros and keep its table
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // generous cap on the run; worst case stays far below this
  localparam int     LIMIT_CYCLES = 2_000_000;
  localparam int     DRAIN_CYCLES = 300;
  localparam longint COORD_MAX    = 64'sd2147483647;
  localparam longint COORD_MIN    = -64'sd2147483648;

  // one input beat, fields unpacked
  typedef struct packed {
    logic [1:0]           cmd;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [15:0]          w;
    logic [15:0]          h;
    logic [FLAG_BITS-1:0] flags;
    logic [15:0]          req_mask;
    logic [15:0]          any_mask;
    logic [15:0]          forbid_mask;
  } beat_t;

  // one answer beat
  typedef struct packed {
    logic        status;
    logic        hit;
    logic [15:0] hit_flags;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;   // x, y, w, h, flags, require, any, forbid (low to high)
  logic [1:0]   s_tuser = '0;   // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;        // hit_flags
  logic [1:0]   m_tuser;        // status, hit (low to high)

  // mirror of the block's table, updated as beats are accepted
  entry_t  box_store [MAX_ENTRIES];
  int      box_count = 0;
  answer_t expected_answers[$];

  int send_idle_pct = 16;
  int recv_idle_pct = 53;
  int err_count     = 0;
  int cycle_count   = 0;
  int n_beats       = 0;
  int n_queries     = 0;
  int n_hits        = 0;
  int n_refused     = 0;

  answer_t seen_answer;
  answer_t due_answer;

  aabb_overlap_flag_query dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one beat to the mirror table and return the answer it must produce.
  // Edge sums are formed in 64 bits so they never wrap.
  function automatic answer_t predict_answer(input beat_t b);
    answer_t a;
    entry_t  e;
    longint  qx, qy, qr, qt, ex, ey, er, et;
    a = '0;
    case (b.cmd)
      CMD_CLEAR: box_count = 0;
      CMD_APPEND: begin
        if (box_count >= MAX_ENTRIES) begin
          a.status = 1'b1;
        end else begin
          box_store[box_count] = '{flags: b.flags, h: b.h, w: b.w, y: b.y, x: b.x};
          box_count++;
        end
      end
      CMD_QUERY: begin
        qx = $signed(b.x);
        qy = $signed(b.y);
        qr = qx + longint'(b.w);
        qt = qy + longint'(b.h);
        for (int i = 0; i < box_count && !a.hit; i++) begin
          e  = box_store[i];
          ex = $signed(e.x);
          ey = $signed(e.y);
          er = ex + longint'(e.w);
          et = ey + longint'(e.h);
          // touching edges count as overlap
          if (qx <= er && qr >= ex && qt >= ey && qy <= et &&
              (e.flags & b.req_mask) == b.req_mask &&
              (e.flags & b.any_mask) != '0 &&
              (e.flags & b.forbid_mask) == '0) begin
            a.hit       = 1'b1;
            a.hit_flags = e.flags;
          end
        end
      end
      default: ;  // unused command: no state change, all-zero answer
    endcase
    return a;
  endfunction

  function automatic beat_t make_beat(input logic [1:0] cmd, input logic [31:0] x, y,
                                      input logic [15:0] w, h, flags, req, any_m, forbid);
    beat_t b;
    b = '{cmd: cmd, x: x, y: y, w: w, h: h, flags: flags,
          req_mask: req, any_mask: any_m, forbid_mask: forbid};
    return b;
  endfunction

  // every field random, so unused fields also toggle every bit
  function automatic beat_t rand_beat();
    return make_beat(2'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // mostly small boxes, with points and the widest size mixed in
  function automatic logic [15:0] rand_size();
    case ($urandom_range(9))
      0:          return 16'd0;
      1:          return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(8));
      default:    return 16'($urandom_range(400));
    endcase
  endfunction

  // Place a query edge around an entry edge: mostly overlapping, sometimes exactly
  // touching, sometimes missing by one or two. Clamp to the signed 32-bit range.
  function automatic logic [31:0] near_coord(input logic [31:0] c,
                                             input logic [15:0] ew, qw);
    longint v;
    v = longint'($signed(c)) + longint'($urandom_range(32'(ew) + 32'(qw) + 4))
        - longint'(qw) - 2;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[31:0];
  endfunction

  // Drive one beat at the falling edge, hold it until accepted, then log what it
  // must produce. Random sender gaps come first.
  task automatic send_beat(input beat_t b);
    answer_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.cmd;
    s_tdata  <= {b.forbid_mask, b.any_mask, b.req_mask, b.flags, b.h, b.w, b.y, b.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = predict_answer(b);
    expected_answers.push_back(due);
    n_beats++;
    if (b.cmd == CMD_QUERY) n_queries++;
    if (due.hit) n_hits++;
    if (due.status) n_refused++;
    @(negedge clk);
  endtask

  // Corners of the coordinate space, touching edges, each mask rule, first-match
  // order and the unused command.
  task automatic test_directed_edges();
    send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    // empty table: nothing to hit
    send_beat(make_beat(CMD_QUERY, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 0));
    // point box at the most negative corner
    send_beat(make_beat(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h0001, 0, 0, 0));
    // widest box at the most positive corner: its far edges lie past 2^31
    send_beat(make_beat(CMD_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 0, 0, 0));
    send_beat(make_beat(CMD_APPEND, 100, 200, 10, 20, 16'h8421, 0, 0, 0));
    // touch the top-right corner of the small box, then miss it by one
    send_beat(make_beat(CMD_QUERY, 110, 220, 0, 0, 0, 0, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 111, 220, 0, 0, 0, 0, 16'hFFFF, 0));
    // touch the bottom-left corner from outside
    send_beat(make_beat(CMD_QUERY, 90, 180, 10, 20, 0, 0, 16'hFFFF, 0));
    // far corners: a wrapping edge sum would hit where no overlap exists
    send_beat(make_beat(CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
                        0, 0, 16'hFFFF, 0));
    // mask rules on the small box
    send_beat(make_beat(CMD_QUERY, 105, 210, 0, 0, 0, 0, 16'h0000, 0));
    send_beat(make_beat(CMD_QUERY, 105, 210, 0, 0, 0, 16'h8420, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 105, 210, 0, 0, 0, 16'h8422, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 105, 210, 0, 0, 0, 0, 16'hFFFF, 16'h0001));
    send_beat(make_beat(CMD_QUERY, 105, 210, 0, 0, 0, 0, 16'hFFFF, 16'h0002));
    // overlapping later entry: first match wins unless masks steer past it
    send_beat(make_beat(CMD_APPEND, 104, 204, 2, 2, 16'h0002, 0, 0, 0));
    send_beat(make_beat(CMD_QUERY, 105, 205, 0, 0, 0, 0, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 105, 205, 0, 0, 0, 0, 16'h0002, 0));
    // unused command carries junk and must leave the table alone
    send_beat(make_beat(CMD_UNUSED, $urandom, $urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(CMD_QUERY, 105, 205, 0, 0, 0, 0, 16'h0002, 0));
    send_beat(make_beat(CMD_CLEAR, $urandom, $urandom, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(CMD_QUERY, 105, 205, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 0));
  endtask

  // Fill every slot, get appends refused, and scan the whole table.
  task automatic test_full_table();
    beat_t b;
    b = rand_beat();
    b.cmd = CMD_CLEAR;
    send_beat(b);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      b = rand_beat();
      b.cmd   = CMD_APPEND;
      b.x     = $urandom_range(1000);
      b.y     = $urandom_range(1000);
      b.w     = 16'($urandom_range(50));
      b.h     = 16'($urandom_range(50));
      b.flags = 16'($urandom) & 16'h7FFF;
      // only the last slot carries the top flag bit
      if (i == MAX_ENTRIES - 1) begin
        b.x     = 5000;
        b.y     = 5000;
        b.w     = 10;
        b.h     = 10;
        b.flags = 16'h8000 | 16'($urandom);
      end
      send_beat(b);
    end
    repeat (2) begin
      b = rand_beat();
      b.cmd = CMD_APPEND;
      send_beat(b);
    end
    send_beat(make_beat(CMD_QUERY, 5005, 5005, 0, 0, 0, 16'h8000, 16'h8000, 0));
    send_beat(make_beat(CMD_QUERY, 32'(-5000), 32'(-5000), 0, 0, 0, 0, 16'hFFFF, 0));
    send_beat(make_beat(CMD_QUERY, 500, 500, 16'd20, 16'd20, 0, 0, 16'hFFFF, 16'h0F00));
    send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(CMD_QUERY, 5005, 5005, 0, 0, 0, 16'h8000, 16'h8000, 0));
  endtask

  // Fill small tables around a moving origin and aim most queries at stored
  // entries with masks built from their flags; the rest is random noise.
  task automatic test_random_mix(input int n_items);
    beat_t       b;
    entry_t      e;
    int          counted;
    int          cap;
    int          pick;
    logic [31:0] origin;
    counted = 0;
    cap     = 16;
    origin  = 0;
    while (counted < n_items) begin
      b    = rand_beat();
      pick = $urandom_range(99);
      if (pick < 4) begin
        b.cmd = CMD_UNUSED;
      end else if (pick < 7 || (pick < 45 && box_count >= cap && cap < MAX_ENTRIES)) begin
        b.cmd = CMD_CLEAR;
        pick  = $urandom_range(99);
        cap   = pick < 85 ? $urandom_range(1, 16) :
                pick < 97 ? $urandom_range(17, 64) : MAX_ENTRIES;
        case ($urandom_range(3))
          0:       origin = 32'h0000_0000;
          1:       origin = 32'h8000_0000;
          2:       origin = 32'h7FFF_F000;
          default: origin = $urandom;
        endcase
      end else if (pick < 45) begin
        b.cmd = CMD_APPEND;
        b.x   = origin + $urandom_range(4000);
        b.y   = origin + $urandom_range(4000);
        b.w   = rand_size();
        b.h   = rand_size();
        if ($urandom_range(3) == 0) b.flags = 16'($urandom & $urandom);
      end else begin
        b.cmd = CMD_QUERY;
        if (box_count > 0 && $urandom_range(3) != 0) begin
          e   = box_store[$urandom_range(box_count - 1)];
          b.w = rand_size();
          b.h = rand_size();
          b.x = near_coord(e.x, e.w, b.w);
          b.y = near_coord(e.y, e.h, b.h);
          case ($urandom_range(5))
            0: ;                           // keep random masks
            1: b.any_mask = '0;            // empty any-mask never matches
            default: begin
              b.req_mask    = e.flags & 16'($urandom & $urandom);
              if ((b.any_mask & e.flags) == '0) b.any_mask |= e.flags & (-e.flags);
              b.forbid_mask = ~e.flags & 16'($urandom & $urandom);
              if ($urandom_range(4) == 0) b.forbid_mask |= e.flags & 16'($urandom);
            end
          endcase
        end else if ($urandom_range(3) != 0) begin
          b.x = origin + $urandom_range(4000);
          b.y = origin + $urandom_range(4000);
          b.w = rand_size();
          b.h = rand_size();
        end
      end
      send_beat(b);
      if (b.cmd != CMD_UNUSED) counted++;
    end
  endtask

  // receiver: stall at random, at the rate of the current phase
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check each accepted answer beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_answer = '{status: m_tuser[0], hit: m_tuser[1], hit_flags: m_tdata};
      if (expected_answers.size() == 0) begin
        $error("unexpected answer beat: status %0d hit %0d hit_flags %h",
               seen_answer.status, seen_answer.hit, seen_answer.hit_flags);
        err_count++;
      end else begin
        due_answer = expected_answers.pop_front();
        if (seen_answer.status !== due_answer.status) begin
          $error("status: expected %0d, got %0d", due_answer.status, seen_answer.status);
          err_count++;
        end
        if (seen_answer.hit !== due_answer.hit) begin
          $error("hit: expected %0d, got %0d", due_answer.hit, seen_answer.hit);
          err_count++;
        end
        if (seen_answer.hit_flags !== due_answer.hit_flags) begin
          $error("hit_flags: expected %h, got %h", due_answer.hit_flags,
                 seen_answer.hit_flags);
          err_count++;
        end
      end
    end
  end

  // watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // hold reset first, release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_full_table();

    // sender lightly idle, receiver often stalled
    send_idle_pct = 16;
    recv_idle_pct = 53;
    test_random_mix(372);
    // swap the two sides
    send_idle_pct = 53;
    recv_idle_pct = 16;
    test_random_mix(372);
    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(372);
    s_tvalid <= 1'b0;

    // drain, then give a stray extra answer time to show up
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d queries with %0d hits, %0d appends refused on a full table.",
             n_beats, n_queries, n_hits, n_refused);
    $display("Covered coordinate corners, touching edges, mask rules and both stall patterns.");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
